// ===== hw/rtl/amcd_pkg.sv =====
// Shared types and constants of the AVI movi chunk demultiplexer.
package amcd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_VIDEO_STREAM = 2'd0;
    localparam logic [1:0] REG_AUDIO_STREAM = 2'd1;
    localparam logic [1:0] REG_MOVI_LENGTH  = 2'd2;
    localparam logic [1:0] REG_VIDEO_LIMIT  = 2'd3;

    localparam logic [6:0]  VIDEO_STREAM_RESET = 7'd0;
    localparam logic [6:0]  AUDIO_STREAM_RESET = 7'd1;
    localparam logic [31:0] MOVI_LENGTH_RESET  = 32'd0;
    localparam logic [31:0] VIDEO_LIMIT_RESET  = 32'(300 * 1024);

    // Chunk id characters
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_W = 8'h77;
    localparam logic [7:0] CH_B = 8'h62;

    localparam logic DEST_VIDEO = 1'b0;
    localparam logic DEST_AUDIO = 1'b1;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_PAD     = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RT_DROP  = 2'd0,
        RT_VIDEO = 2'd1,
        RT_AUDIO = 2'd2
    } route_t;

    typedef struct packed {
        logic [31:0] frame_number;
        logic        chunk_last;
        logic        destination;
        logic [7:0]  payload_byte;
    } item_t;

    // Write side of the queue
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_wr_t;

endpackage

// ===== hw/rtl/amcd_front.sv =====
// Front end: configuration registers, chunk header parser and payload router.
module amcd_front
    import amcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        q_full,
    output q_wr_t       q_wr
);

    logic [6:0]  video_stream_reg;
    logic [6:0]  audio_stream_reg;
    logic [31:0] movi_length_reg;
    logic [31:0] video_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [55:0] shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] remain_reg, remain_next;
    route_t      route_reg, route_next;
    logic        pad_reg, pad_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [31:0] frame_reg, frame_next;

    logic        s_accept;
    logic [63:0] header;
    logic [31:0] size;
    logic [6:0]  sid;
    logic        is_dc;
    logic        is_wb;
    logic [31:0] remain_dec;
    logic        last;

    function automatic logic [3:0] digit_value(input logic [7:0] ch);
        logic [3:0] d;
        d = (ch >= CH_0 && ch <= CH_9) ? ch[3:0] : 4'd0;
        return d;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = ~q_full;
    assign s_accept  = s_tvalid & s_tready;

    // Completed header with the current byte on top
    assign header = {s_tdata, shift_reg};
    assign size   = header[63:32];
    assign sid    = 7'(digit_value(header[7:0])) * 7'd10 + 7'(digit_value(header[15:8]));
    assign is_dc  = (header[23:16] == CH_D) && (header[31:24] == CH_C);
    assign is_wb  = (header[23:16] == CH_W) && (header[31:24] == CH_B);
    assign remain_dec = remain_reg - 32'd1;
    assign last       = (remain_dec == 32'd0);

    always_comb begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        route_next    = route_reg;
        pad_next      = pad_reg;
        consumed_next = consumed_reg;
        frame_next    = frame_reg;
        q_wr.valid             = 1'b0;
        q_wr.item.payload_byte = s_tdata;
        q_wr.item.destination  = (route_reg == RT_AUDIO) ? DEST_AUDIO : DEST_VIDEO;
        q_wr.item.chunk_last   = last;
        q_wr.item.frame_number = frame_reg;

        if (s_accept && phase_reg != PH_DONE) begin
            if (phase_reg == PH_HEADER && count_reg == 3'd0
                    && consumed_reg >= movi_length_reg) begin
                phase_next = PH_DONE;
            end else begin
                if (consumed_reg != 32'hFFFF_FFFF) begin
                    consumed_next = consumed_reg + 32'd1;
                end
                unique case (phase_reg)
                    PH_HEADER: begin
                        shift_next = {s_tdata, shift_reg[55:8]};
                        count_next = count_reg + 3'd1;
                        if (count_reg == 3'd7) begin
                            route_next = RT_DROP;
                            if (sid == video_stream_reg && is_dc) begin
                                if (size != 32'd0 && size <= video_limit_reg) begin
                                    route_next = RT_VIDEO;
                                end
                            end else if (sid == audio_stream_reg && is_wb) begin
                                route_next = RT_AUDIO;
                            end
                            remain_next = size;
                            pad_next    = size[0];
                            phase_next  = (size != 32'd0) ? PH_PAYLOAD : PH_HEADER;
                        end
                    end
                    PH_PAYLOAD: begin
                        remain_next = remain_dec;
                        q_wr.valid  = (route_reg == RT_VIDEO) || (route_reg == RT_AUDIO);
                        if (last) begin
                            if (route_reg == RT_VIDEO) begin
                                frame_next = frame_reg + 32'd1;
                            end
                            phase_next = pad_reg ? PH_PAD : PH_HEADER;
                        end
                    end
                    PH_PAD: begin
                        pad_next   = 1'b0;
                        phase_next = PH_HEADER;
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            video_stream_reg <= VIDEO_STREAM_RESET;
            audio_stream_reg <= AUDIO_STREAM_RESET;
            movi_length_reg  <= MOVI_LENGTH_RESET;
            video_limit_reg  <= VIDEO_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_VIDEO_STREAM: video_stream_reg <= cfg_data[6:0];
                REG_AUDIO_STREAM: audio_stream_reg <= cfg_data[6:0];
                REG_MOVI_LENGTH:  movi_length_reg  <= cfg_data;
                REG_VIDEO_LIMIT:  video_limit_reg  <= cfg_data;
                default:          video_limit_reg  <= video_limit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            shift_reg    <= '0;
            count_reg    <= '0;
            remain_reg   <= '0;
            route_reg    <= RT_DROP;
            pad_reg      <= 1'b0;
            consumed_reg <= '0;
            frame_reg    <= '0;
        end else begin
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            remain_reg   <= remain_next;
            route_reg    <= route_next;
            pad_reg      <= pad_next;
            consumed_reg <= consumed_next;
            frame_reg    <= frame_next;
        end
    end

endmodule

// ===== hw/rtl/amcd_queue.sv =====
// Small register queue between the parser and the output stage.
module amcd_queue
    import amcd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  q_wr_t wr,
    output logic  full,
    output logic  empty,
    input  logic  rd,
    output item_t rd_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push    = wr.valid & ~full;
    assign pop     = rd & ~empty;
    assign rd_item = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wr.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/amcd_back.sv =====
// Output stage: registers one result and drives the master stream.
module amcd_back
    import amcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    output logic        q_rd,
    input  item_t       q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic [0:0]  m_tuser
);

    logic  valid_reg;
    item_t item_reg;
    logic  load;

    // Refill whenever the holding register is free or being emptied
    assign load = ~q_empty & (~valid_reg | m_tready);
    assign q_rd = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= q_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {item_reg.frame_number, item_reg.payload_byte};
    assign m_tlast  = item_reg.chunk_last;
    assign m_tuser  = item_reg.destination;

endmodule

// ===== hw/rtl/avi_movi_chunk_demux_top.sv =====
// Top level of the AVI movi chunk demultiplexer.
//
// Takes the movi list payload one byte per transaction on the s_ stream and
// puts the payload bytes of accepted chunks out on the m_ stream. Each chunk
// header (four-character id, little-endian 32-bit size) is parsed on the fly;
// '##dc' chunks on the video stream (size nonzero and within video_limit) go
// to video, '##wb' chunks on the audio stream go to audio, everything else,
// headers and pad bytes included, is swallowed without a result. The
// parser decides each byte's fate in the cycle it is accepted, with one
// compare of the size against the limit on the last header byte, so a byte
// can be taken every clock while the queue is not full. Results pass through
// a short queue and an output register, so s_tready only drops once the
// queue is full behind a stalled m_ side. Once movi_length bytes are
// consumed at a chunk boundary the block swallows all further bytes until
// reset. Configuration writes are always taken (cfg_ready is tied high) and
// must only be issued while idle.
module avi_movi_chunk_demux_top
    import amcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT  // 2 or more
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,   // 0 video_stream, 1 audio_stream, 2 movi_length,
                                     // 3 video_limit
    input  logic [31:0] cfg_data,
    // byte input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    // routed payload stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [7:0] payload_byte, [39:8] frame_number
    output logic        m_tlast,     // chunk_last
    output logic [0:0]  m_tuser      // [0] destination: 0 video, 1 audio
);

    q_wr_t q_wr;
    logic  q_full;
    logic  q_empty;
    logic  q_rd;
    item_t q_item;

    amcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    amcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .full    (q_full),
        .empty   (q_empty),
        .rd      (q_rd),
        .rd_item (q_item)
    );

    amcd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rd     (q_rd),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the AVI movi chunk demultiplexer: chunk streams in, routed bytes checked.
module tb_top;
    import amcd_pkg::*;

    localparam int HOLD_CYCLES   = 300;  // long receiver hold-off to fill the block
    localparam int SETTLE_CYCLES = 8;    // covers the byte-to-result latency and then some

    typedef enum int {
        RX_ALWAYS,
        RX_LIGHT,
        RX_HEAVY,
        RX_PATTERN
    } rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    avi_movi_chunk_demux_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Predictor copy of the registers and parser state
    logic [6:0]  video_stream_q;
    logic [6:0]  audio_stream_q;
    logic [31:0] movi_length_q;
    logic [31:0] video_limit_q;
    phase_t      parse_phase;
    logic [63:0] hdr_shift;
    logic [2:0]  hdr_count;
    logic [31:0] payload_left;
    route_t      chunk_route;
    logic        pad_due;
    logic [31:0] consumed;
    logic [31:0] frame_count;
    item_t       pending_routed[$];
    item_t       head_item;

    // Stimulus and handshake control
    int       errors        = 0;
    int       bytes_sent    = 0;
    int       burst_left    = 0;
    bit       tx_gaps       = 1'b1;
    rx_mode_t rx_mode       = RX_ALWAYS;
    int       hold_requests = 0;
    int       hold_seen     = 0;
    int       hold_left     = 0;
    int       rx_tick       = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [6:0] digit_of(input logic [7:0] ch);
        if (ch >= CH_0 && ch <= CH_9) return 7'(ch - CH_0);
        return 7'd0;
    endfunction

    function automatic logic [7:0] non_digit();
        if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, CH_0 - 1));
        return 8'($urandom_range(CH_9 + 1, 255));
    endfunction

    // Works out the routed result, if any, of one accepted byte
    task automatic demux_byte(input logic [7:0] b);
        logic [7:0]  c0, c1, c2, c3;
        logic [31:0] size;
        logic [6:0]  sid;
        logic        is_dc, is_wb, last;
        item_t       res;
        if (parse_phase == PH_DONE) return;
        // chunk boundary at or past the movi length: parsing stops for good
        if (parse_phase == PH_HEADER && hdr_count == 3'd0 && consumed >= movi_length_q) begin
            parse_phase = PH_DONE;
            return;
        end
        if (consumed != 32'hFFFF_FFFF) consumed++;
        case (parse_phase)
            PH_HEADER: begin
                hdr_shift = {b, hdr_shift[63:8]};
                hdr_count++;
                if (hdr_count == 3'd0) begin
                    {size, c3, c2, c1, c0} = hdr_shift;
                    sid   = digit_of(c0) * 7'd10 + digit_of(c1);
                    is_dc = (c2 == CH_D) && (c3 == CH_C);
                    is_wb = (c2 == CH_W) && (c3 == CH_B);
                    chunk_route = RT_DROP;
                    // video test wins when both streams are the same
                    if (sid == video_stream_q && is_dc) begin
                        if (size != 32'd0 && size <= video_limit_q) chunk_route = RT_VIDEO;
                    end else if (sid == audio_stream_q && is_wb) begin
                        chunk_route = RT_AUDIO;
                    end
                    payload_left = size;
                    pad_due      = size[0];
                    parse_phase  = (size != 32'd0) ? PH_PAYLOAD : PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                payload_left--;
                last = (payload_left == 32'd0);
                if (chunk_route != RT_DROP) begin
                    res.payload_byte = b;
                    res.destination  = (chunk_route == RT_AUDIO) ? DEST_AUDIO : DEST_VIDEO;
                    res.chunk_last   = last;
                    res.frame_number = frame_count;
                    pending_routed.push_back(res);
                end
                if (last) begin
                    if (chunk_route == RT_VIDEO) frame_count++;
                    parse_phase = pad_due ? PH_PAD : PH_HEADER;
                end
            end
            default: begin
                // pad byte after an odd size
                pad_due     = 1'b0;
                parse_phase = PH_HEADER;
            end
        endcase
    endtask

    // Offers one byte, honouring bursts and gaps; called and returns at a falling edge
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (tx_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        demux_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_VIDEO_STREAM: video_stream_q = val[6:0];
            REG_AUDIO_STREAM: audio_stream_q = val[6:0];
            REG_MOVI_LENGTH:  movi_length_q  = val;
            default:          video_limit_q  = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Sender pauses until every routed byte is back and the pipeline is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_routed.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic push_header(input logic [7:0] c0, c1, c2, c3, input logic [31:0] size);
        push_byte(c0);
        push_byte(c1);
        push_byte(c2);
        push_byte(c3);
        push_byte(size[7:0]);
        push_byte(size[15:8]);
        push_byte(size[23:16]);
        push_byte(size[31:24]);
    endtask

    task automatic send_chunk(input logic [7:0] c0, c1, c2, c3, input int size);
        push_header(c0, c1, c2, c3, 32'(size));
        repeat (size) push_byte(8'($urandom_range(0, 255)));
        if (size % 2 == 1) push_byte(8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed chunks aimed at the configured streams, some near misses and noise
    task automatic random_chunk();
        int         sid, roll, size;
        logic [7:0] c0, c1, c2, c3;
        roll = $urandom_range(0, 9);
        if (roll < 4 && video_stream_q < 7'd100) sid = video_stream_q;
        else if (roll < 8 && audio_stream_q < 7'd100) sid = audio_stream_q;
        else sid = $urandom_range(0, 99);
        c0 = CH_0 + 8'(sid / 10);
        c1 = CH_0 + 8'(sid % 10);
        // a non-digit counts as zero
        if (c0 == CH_0 && $urandom_range(0, 2) == 0) c0 = non_digit();
        if (c1 == CH_0 && $urandom_range(0, 2) == 0) c1 = non_digit();
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            c2 = CH_D;
            c3 = CH_C;
        end else if (roll < 8) begin
            c2 = CH_W;
            c3 = CH_B;
        end else if (roll == 8) begin
            // swapped kind letters
            c2 = ($urandom_range(0, 1) != 0) ? CH_D : CH_W;
            c3 = (c2 == CH_D) ? CH_B : CH_C;
        end else begin
            c0 = 8'($urandom_range(0, 255));
            c1 = 8'($urandom_range(0, 255));
            c2 = 8'($urandom_range(0, 255));
            c3 = 8'($urandom_range(0, 255));
        end
        roll = $urandom_range(0, 99);
        if (video_limit_q < 32'd64 && roll < 30) begin
            // around the video size limit
            size = int'(video_limit_q) - 1 + int'($urandom_range(0, 2));
            if (size < 0) size = 0;
        end else if (roll < 38) begin
            size = 0;
        end else if (roll < 90) begin
            size = $urandom_range(1, 24);
        end else begin
            size = $urandom_range(25, 64);
        end
        send_chunk(c0, c1, c2, c3, size);
    endtask

    task automatic random_phase(input int budget);
        int target;
        target = bytes_sent + budget;
        while (bytes_sent < target) random_chunk();
    endtask

    task automatic test_directed();
        write_reg(REG_MOVI_LENGTH, 32'hFFFF_FFFF);
        // odd video chunk: top byte value, then its pad
        push_header(CH_0, CH_0, CH_D, CH_C, 32'd1);
        push_byte(8'hFF);
        push_byte(8'h00);
        // audio chunk with a non-digit tens character
        push_header(8'hFF, CH_0 + 8'd1, CH_W, CH_B, 32'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        // zero-size video chunk routes nothing
        push_header(CH_0, CH_0, CH_D, CH_C, 32'd0);
        drain_results();
    endtask

    task automatic test_default_routing();
        rx_mode = RX_LIGHT;
        tx_gaps = 1'b1;
        random_phase(300);
        drain_results();
    endtask

    task automatic test_video_limit();
        write_reg(REG_VIDEO_LIMIT, 32'd0);
        rx_mode = RX_HEAVY;
        random_phase(150);
        drain_results();
        write_reg(REG_VIDEO_LIMIT, 32'hFFFF_FFFF);
        rx_mode = RX_ALWAYS;
        tx_gaps = 1'b0;
        random_phase(200);
        drain_results();
        write_reg(REG_VIDEO_LIMIT, 32'd7);
        rx_mode = RX_PATTERN;
        tx_gaps = 1'b1;
        random_phase(200);
        drain_results();
        write_reg(REG_VIDEO_LIMIT, VIDEO_LIMIT_RESET);
    endtask

    task automatic test_stream_select();
        write_reg(REG_VIDEO_STREAM, 32'd99);
        write_reg(REG_AUDIO_STREAM, 32'd98);
        rx_mode = RX_HEAVY;
        random_phase(150);
        drain_results();
        // no stream can match
        write_reg(REG_VIDEO_STREAM, 32'd100);
        write_reg(REG_AUDIO_STREAM, 32'd100);
        rx_mode = RX_LIGHT;
        random_phase(100);
        drain_results();
        // shared stream number
        write_reg(REG_VIDEO_STREAM, 32'd5);
        write_reg(REG_AUDIO_STREAM, 32'd5);
        rx_mode = RX_PATTERN;
        random_phase(150);
        drain_results();
        write_reg(REG_VIDEO_STREAM, 32'd37);
        write_reg(REG_AUDIO_STREAM, 32'd0);
        rx_mode = RX_LIGHT;
        random_phase(150);
        drain_results();
        write_reg(REG_VIDEO_STREAM, 32'(VIDEO_STREAM_RESET));
        write_reg(REG_AUDIO_STREAM, 32'(AUDIO_STREAM_RESET));
    endtask

    // Receiver holds off while bytes keep coming, so s_tready must drop
    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        tx_gaps = 1'b0;
        hold_requests++;
        send_chunk(CH_0, CH_0, CH_D, CH_C, 64);
        tx_gaps = 1'b1;
        rx_mode = RX_LIGHT;
        random_phase(150);
        drain_results();
    endtask

    task automatic test_end_of_movi();
        // limit falls inside the next chunk, which must still be finished
        write_reg(REG_MOVI_LENGTH, consumed + 32'd5);
        send_chunk(CH_0, CH_0, CH_D, CH_C, 12);
        // everything after the boundary is swallowed
        random_phase(40);
        drain_results();
        write_reg(REG_MOVI_LENGTH, 32'd0);
        random_phase(20);
        drain_results();
    endtask

    // Receiver: own stall pattern plus the long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            rx_tick++;
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY:  m_tready <= ($urandom_range(0, 2) == 0);
                    default:   m_tready <= ((rx_tick % 11) < 6);
                endcase
            end
        end
    end

    // Result checker: each transaction against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_routed.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
            end else begin
                head_item = pending_routed.pop_front();
                if (m_tdata[7:0] !== head_item.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, expected %h",
                                              m_tdata[7:0], head_item.payload_byte));
                if (m_tuser[0] !== head_item.destination)
                    report_mismatch($sformatf("destination %b, expected %b",
                                              m_tuser[0], head_item.destination));
                if (m_tlast !== head_item.chunk_last)
                    report_mismatch($sformatf("chunk_last %b, expected %b",
                                              m_tlast, head_item.chunk_last));
                if (m_tdata[39:8] !== head_item.frame_number)
                    report_mismatch($sformatf("frame_number %h, expected %h",
                                              m_tdata[39:8], head_item.frame_number));
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_VIDEO_STREAM;
        cfg_data       = 32'd0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        video_stream_q = VIDEO_STREAM_RESET;
        audio_stream_q = AUDIO_STREAM_RESET;
        movi_length_q  = MOVI_LENGTH_RESET;
        video_limit_q  = VIDEO_LIMIT_RESET;
        parse_phase    = PH_HEADER;
        hdr_shift      = 64'd0;
        hdr_count      = 3'd0;
        payload_left   = 32'd0;
        chunk_route    = RT_DROP;
        pad_due        = 1'b0;
        consumed       = 32'd0;
        frame_count    = 32'd0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_default_routing();
        test_video_limit();
        test_stream_select();
        test_backpressure();
        test_end_of_movi();

        drain_results();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/amcd_pkg.sv
hw/rtl/amcd_front.sv
hw/rtl/amcd_queue.sv
hw/rtl/amcd_back.sv
hw/rtl/avi_movi_chunk_demux_top.sv
tb/tb_top.sv
